### design/rgb_to_ansi16_color_top_assert.svh
// Assertion macros shared by the RGB to 16-color palette RTL.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef RGB_TO_ANSI16_COLOR_TOP_ASSERT_SVH
`define RGB_TO_ANSI16_COLOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RTA16_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define RTA16_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### design/rta16_pkg.sv
// Shared types and palette codes for the RGB to 16-color palette pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rta16_pkg;

    localparam int CODE_BITS = 4;

    localparam logic [CODE_BITS-1:0] COLOR_BLACK   = 4'd0;
    localparam logic [CODE_BITS-1:0] COLOR_RED     = 4'd1;
    localparam logic [CODE_BITS-1:0] COLOR_GREEN   = 4'd2;
    localparam logic [CODE_BITS-1:0] COLOR_YELLOW  = 4'd3;
    localparam logic [CODE_BITS-1:0] COLOR_BLUE    = 4'd4;
    localparam logic [CODE_BITS-1:0] COLOR_MAGENTA = 4'd5;
    localparam logic [CODE_BITS-1:0] COLOR_CYAN    = 4'd6;
    localparam logic [CODE_BITS-1:0] COLOR_SILVER  = 4'd7;
    localparam logic [CODE_BITS-1:0] COLOR_GRAY    = 4'd8;
    localparam logic [CODE_BITS-1:0] COLOR_WHITE   = 4'd15;
    localparam logic [CODE_BITS-1:0] BRIGHT_MASK   = 4'd8;

    // Which channel holds the maximum; red wins ties, then green.
    typedef enum logic [2:0] {
        MAX_RED   = 3'b001,
        MAX_GREEN = 3'b010,
        MAX_BLUE  = 3'b100
    } max_sel_t;

    // Per-pixel decisions handed from the metrics stage to the classifier.
    typedef struct packed {
        logic                 zero;    // max == min
        logic                 sat_ok;  // saturation >= 0.3
        logic                 half;    // max >= 0.5
        logic                 bright;  // lightness >= 0.64
        logic [CODE_BITS-1:0] gray;    // code used when chroma is zero
    } flags_t;

endpackage

`default_nettype wire

### design/rta16_minmax.sv
// Stage 1: registers the channels with their maximum, minimum and max channel.
// Depends on rta16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rta16_minmax
    import rta16_pkg::*;
#(
    parameter int CB = 8
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [CB-1:0] red,
    input  wire logic [CB-1:0] green,
    input  wire logic [CB-1:0] blue,
    output logic      [CB-1:0] red_reg,
    output logic      [CB-1:0] green_reg,
    output logic      [CB-1:0] blue_reg,
    output logic      [CB-1:0] hi_reg,
    output logic      [CB-1:0] lo_reg,
    output max_sel_t           sel_reg
);

    logic [CB-1:0] hi_next;
    logic [CB-1:0] lo_next;
    max_sel_t      sel_next;

    always_comb begin
        if (red >= green && red >= blue) begin
            sel_next = MAX_RED;
            hi_next  = red;
        end else if (green >= blue) begin
            sel_next = MAX_GREEN;
            hi_next  = green;
        end else begin
            sel_next = MAX_BLUE;
            hi_next  = blue;
        end
        lo_next = red;
        if (green < lo_next) lo_next = green;
        if (blue < lo_next) lo_next = blue;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

`default_nettype wire

### design/rta16_metrics.sv
// Stage 2: chroma, scaled hue and the threshold decisions, all by exact
// integer cross-multiplication. Depends on rta16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rta16_metrics
    import rta16_pkg::*;
#(
    parameter int CB = 8
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [CB-1:0] red,
    input  wire logic [CB-1:0] green,
    input  wire logic [CB-1:0] blue,
    input  wire logic [CB-1:0] hi,
    input  wire logic [CB-1:0] lo,
    input  wire max_sel_t      sel,
    output logic      [CB-1:0] d_reg,
    output logic      [CB+3:0] hue_reg,
    output flags_t             flags_reg
);

    localparam int CH_MAX = (1 << CB) - 1;
    localparam int HW     = CB + 5;    // hue arithmetic, wraps modulo 2^HW
    localparam int LW     = CB + 7;    // threshold products

    localparam logic [LW-1:0] BRIGHT_LIM = LW'(32 * CH_MAX);
    localparam logic [LW-1:0] WHITE_LIM  = LW'(4 * CH_MAX);
    localparam logic [LW-1:0] SILVER_LIM = LW'(53 * CH_MAX);
    localparam logic [LW-1:0] GRAY_LIM   = LW'(27 * CH_MAX);
    localparam logic [LW-1:0] HALF_LIM   = LW'(CH_MAX);

    logic [CB-1:0] d;
    logic [HW-1:0] r_x, g_x, b_x, d_x;
    logic [HW-1:0] hue_wide;
    logic [LW-1:0] hi_w, lo_w, d_w;
    flags_t        flags_next;

    assign d   = hi - lo;
    assign r_x = HW'(red);
    assign g_x = HW'(green);
    assign b_x = HW'(blue);
    assign d_x = HW'(d);

    always_comb begin
        case (sel)
            MAX_RED: begin
                if (green >= blue) hue_wide = (g_x - b_x) << 1;
                else               hue_wide = HW'(12 * d_x) - ((b_x - g_x) << 1);
            end
            MAX_GREEN: hue_wide = HW'(4 * d_x) + (b_x << 1) - (r_x << 1);
            MAX_BLUE:  hue_wide = HW'(8 * d_x) + (r_x << 1) - (g_x << 1);
            default:   hue_wide = '0;
        endcase
    end

    assign hi_w = LW'(hi);
    assign lo_w = LW'(lo);
    assign d_w  = LW'(d);

    always_comb begin
        flags_next.zero   = (d == '0);
        flags_next.sat_ok = (10 * d_w >= 3 * hi_w);
        flags_next.half   = ((hi_w << 1) >= HALF_LIM);
        flags_next.bright = (LW'(25 * (hi_w + lo_w)) >= BRIGHT_LIM);
        if (LW'(5 * hi_w) > WHITE_LIM)        flags_next.gray = COLOR_WHITE;
        else if (LW'(100 * hi_w) > SILVER_LIM) flags_next.gray = COLOR_SILVER;
        else if (LW'(100 * hi_w) > GRAY_LIM)   flags_next.gray = COLOR_GRAY;
        else                                   flags_next.gray = COLOR_BLACK;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg     <= d;
            hue_reg   <= hue_wide[CB+3:0];
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

### design/rta16_classify.sv
// Stage 3: hue sector selection and final palette code into the output register.
// Depends on rta16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rta16_classify
    import rta16_pkg::*;
#(
    parameter int CB = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [CB-1:0]        d,
    input  wire logic [CB+3:0]        hue,
    input  wire flags_t               flags,
    output logic      [CODE_BITS-1:0] code_reg
);

    localparam int KW = CB + 4;

    logic [KW-1:0]        d_k;
    logic [CODE_BITS-1:0] hue_code;
    logic [CODE_BITS-1:0] code_next;

    assign d_k = KW'(d);

    // Boundaries sit at odd multiples of d; a hue on a boundary takes the lower color.
    always_comb begin
        if (hue <= d_k)                hue_code = COLOR_RED;
        else if (hue <= KW'(3 * d_k))  hue_code = COLOR_YELLOW;
        else if (hue <= KW'(5 * d_k))  hue_code = COLOR_GREEN;
        else if (hue <= KW'(7 * d_k))  hue_code = COLOR_CYAN;
        else if (hue <= KW'(9 * d_k))  hue_code = COLOR_BLUE;
        else if (hue <= KW'(11 * d_k)) hue_code = COLOR_MAGENTA;
        else                           hue_code = COLOR_RED;
    end

    always_comb begin
        if (flags.zero) begin
            code_next = flags.gray;
        end else begin
            if (flags.sat_ok)    code_next = hue_code;
            else if (flags.half) code_next = COLOR_SILVER;
            else                 code_next = COLOR_BLACK;
            if (flags.bright) code_next = code_next | BRIGHT_MASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) code_reg <= code_next;
    end

endmodule

`default_nettype wire

### design/rgb_to_ansi16_color_top.sv
// RGB pixel to 16-color terminal palette code, three-stage pipeline.
// Depends on rta16_pkg, rta16_minmax, rta16_metrics, rta16_classify and
// rgb_to_ansi16_color_top_assert.svh.
//
// Usage:
//   Input stream s_*: one pixel per transaction, s_tdata holds red, green and
//   blue of CHANNEL_BITS each, red in the lowest bits, zero-padded to bytes.
//   Output stream m_*: one palette code per pixel, in m_tdata[3:0]
//   (bit 0 red, bit 1 green, bit 2 blue, bit 3 bright).
//   An input transaction reaches the output through the min/max stage, the
//   metrics stage (hue and threshold products) and the classifier into the output
//   register. Throughput is one pixel per cycle with no gaps while m_tready is
//   high.
//   Each stage advances when it is empty or the stage after it advances, so a
//   stall on m_tready holds every item in place and bubbles are squeezed out;
//   s_tready drops only when all three stages are full and m_tready is low.
//   Synchronous active-low reset empties the pipeline; no pixel state is kept.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_ansi16_color_top
    import rta16_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // fields from bit 0: red, green, blue (CHANNEL_BITS each), zero pad
    input  wire logic [((3*CHANNEL_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // fields from bit 0: color_code (4 bits), zero pad
    output logic [7:0]                                m_tdata
);

    localparam int CB = CHANNEL_BITS;

    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;
    logic          v3_reg, v3_next;
    logic          adv1, adv2, adv3;

    logic [CB-1:0]        r1, g1, b1, hi1, lo1;
    max_sel_t             sel1;
    logic [CB-1:0]        d2;
    logic [CB+3:0]        hue2;
    flags_t               flags2;
    logic [CODE_BITS-1:0] code3;

    // A stage moves when it is empty or its successor moves.
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        v3_next = v3_reg;
        if (adv1) v1_next = s_tvalid;
        if (adv2) v2_next = v1_reg;
        if (adv3) v3_next = v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    rta16_minmax #(.CB(CB)) u_minmax (
        .aclk      (aclk),
        .en        (adv1),
        .red       (s_tdata[CB-1:0]),
        .green     (s_tdata[2*CB-1:CB]),
        .blue      (s_tdata[3*CB-1:2*CB]),
        .red_reg   (r1),
        .green_reg (g1),
        .blue_reg  (b1),
        .hi_reg    (hi1),
        .lo_reg    (lo1),
        .sel_reg   (sel1)
    );

    rta16_metrics #(.CB(CB)) u_metrics (
        .aclk      (aclk),
        .en        (adv2),
        .red       (r1),
        .green     (g1),
        .blue      (b1),
        .hi        (hi1),
        .lo        (lo1),
        .sel       (sel1),
        .d_reg     (d2),
        .hue_reg   (hue2),
        .flags_reg (flags2)
    );

    rta16_classify #(.CB(CB)) u_classify (
        .aclk     (aclk),
        .en       (adv3),
        .d        (d2),
        .hue      (hue2),
        .flags    (flags2),
        .code_reg (code3)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {4'b0000, code3};

`include "rgb_to_ansi16_color_top_assert.svh"

    `RTA16_ASSERT_IMPL(a_ready_when_not_full, !(v1_reg && v2_reg && v3_reg), s_tready)
    `RTA16_ASSERT_NEXT(a_accept_fills_stage1, s_tvalid && s_tready, v1_reg)
    `RTA16_ASSERT_NEXT(a_stall_holds_stage2, v2_reg && v3_reg && !m_tready, v2_reg && v3_reg)

endmodule

`default_nettype wire
